// ===== rtl/tds_pkg.sv =====
// tds_pkg: shared types and codes for the timer deadline scheduler
// depends on nothing; imported by every rtl module
`default_nettype none
package tds_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_CANCEL   = 2'd2;

    localparam logic [1:0] KIND_SCHEDULED = 2'd0;
    localparam logic [1:0] KIND_FIRED     = 2'd1;
    localparam logic [1:0] KIND_NEXT      = 2'd2;
    localparam logic [1:0] KIND_FULL      = 2'd3;

    typedef enum logic [1:0] {
        SCAN_FREE,
        SCAN_DUE,
        SCAN_DELTA
    } scan_mode_t;

    typedef struct packed {
        logic        in_load;
        logic        scan_clr;
        logic        scan_run;
        scan_mode_t  scan_mode;
        logic        purge;
        logic        cancel;
        logic        sched;
        logic        fire;
        logic        out_load;
        logic [1:0]  out_kind;
        logic        out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic found;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        logic [47:0] deadline;
        logic [31:0] interval;
        logic        repeat_flag;
        logic [3:0]  queue;
        logic [15:0] tag;
    } slot_t;

endpackage
`default_nettype wire

// ===== rtl/tds_in_if.sv =====
// tds_in_if: input channel of the timer deadline scheduler
// valid/ready handshake with the command payload
`default_nettype none
interface tds_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] interval;
    logic        repeat_flag;
    logic [3:0]  target_queue;
    logic [15:0] task_tag;
    logic [3:0]  cancel_handle;

    modport source (output valid, command, interval, repeat_flag, target_queue, task_tag,
                    cancel_handle, input ready);
    modport sink (input valid, command, interval, repeat_flag, target_queue, task_tag,
                  cancel_handle, output ready);
endinterface
`default_nettype wire

// ===== rtl/tds_out_if.sv =====
// tds_out_if: result channel of the timer deadline scheduler
// valid/ready handshake with the result payload
`default_nettype none
interface tds_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  handle;
    logic [3:0]  fired_queue;
    logic [15:0] fired_tag;
    logic [31:0] next_delta;
    logic        last;

    modport source (output valid, kind, handle, fired_queue, fired_tag, next_delta, last,
                    input ready);
    modport sink (input valid, kind, handle, fired_queue, fired_tag, next_delta, last,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/tds_dp.sv =====
// tds_dp: slot table, time counter, slot scanner and result register
// depends on tds_pkg; driven by tds_ctrl
`default_nettype none
module tds_dp
    import tds_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] in_interval,
    input  wire logic        in_repeat_flag,
    input  wire logic [3:0]  in_target_queue,
    input  wire logic [15:0] in_task_tag,
    input  wire logic [3:0]  in_cancel_handle,
    input  wire dp_cmd_t     cmd,
    output dp_stat_t         stat,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       out_kind,
    output logic [3:0]       out_handle,
    output logic [3:0]       out_fired_queue,
    output logic [15:0]      out_fired_tag,
    output logic [31:0]      out_next_delta,
    output logic             out_last
);

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    slot_t mem [SLOTS];

    logic [47:0]      now_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] en_reg;
    logic [SLOTS-1:0] done_reg;

    logic [31:0] l_iv_reg;
    logic        l_rep_reg;
    logic [3:0]  l_q_reg;
    logic [15:0] l_tag_reg;
    logic [3:0]  l_h_reg;

    logic [IW-1:0] idx_reg;
    logic          issue_reg;
    logic          p_vld_reg;
    logic [IW-1:0] p_idx_reg;
    slot_t         rd_reg;

    logic          found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [47:0]   best_val_reg;
    slot_t         best_slot_reg;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [3:0]    out_handle_reg;
    logic [3:0]    out_queue_reg;
    logic [15:0]   out_tag_reg;
    logic [31:0]   out_delta_reg;
    logic          out_last_reg;

    logic [47:0]   lag;
    logic [47:0]   ahead;
    logic [47:0]   ahead_sat;
    logic          due;
    logic          take;
    logic [47:0]   cand_val;
    logic [31:0]   iv1;
    logic          mem_we;
    slot_t         mem_wd;
    logic [IW-1:0] cancel_idx;
    logic          cancel_ok;

    assign lag       = now_reg - rd_reg.deadline;
    assign ahead     = rd_reg.deadline - now_reg;
    assign ahead_sat = ahead[47] ? 48'd0 : ahead;
    assign due       = valid_reg[p_idx_reg] && !done_reg[p_idx_reg] && !lag[47];
    assign cand_val  = (cmd.scan_mode == SCAN_DUE) ? lag : ahead_sat;
    assign iv1       = (l_iv_reg == 32'd0) ? 32'd1 : l_iv_reg;
    assign cancel_idx = IW'(l_h_reg);
    assign cancel_ok  = (32'(l_h_reg) < 32'(SLOTS));

    always_comb
    begin
        take = 1'b0;
        if (p_vld_reg && cmd.scan_run)
        begin
            unique case (cmd.scan_mode)
                SCAN_FREE:  take = !valid_reg[p_idx_reg] && !found_reg;
                SCAN_DUE:   take = due && (!found_reg || lag > best_val_reg);
                SCAN_DELTA: take = valid_reg[p_idx_reg] &&
                                   (!found_reg || ahead_sat < best_val_reg);
                default:    take = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        mem_we = cmd.sched || (cmd.fire && best_slot_reg.repeat_flag);
        if (cmd.sched)
        begin
            mem_wd.deadline    = now_reg + {16'd0, iv1};
            mem_wd.interval    = iv1;
            mem_wd.repeat_flag = l_rep_reg;
            mem_wd.queue       = l_q_reg;
            mem_wd.tag         = l_tag_reg;
        end
        else
        begin
            mem_wd          = best_slot_reg;
            mem_wd.deadline = best_slot_reg.deadline + {16'd0, best_slot_reg.interval};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[best_idx_reg] <= mem_wd;
        end
        if (cmd.scan_run && issue_reg)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    // payload, scan index, best-candidate and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            l_iv_reg  <= in_interval;
            l_rep_reg <= in_repeat_flag;
            l_q_reg   <= in_target_queue;
            l_tag_reg <= in_task_tag;
            l_h_reg   <= in_cancel_handle;
        end
        if (cmd.scan_run && issue_reg)
        begin
            p_idx_reg <= idx_reg;
        end
        if (take)
        begin
            best_idx_reg  <= p_idx_reg;
            best_val_reg  <= cand_val;
            best_slot_reg <= rd_reg;
        end
        if (cmd.out_load)
        begin
            out_kind_reg   <= cmd.out_kind;
            out_last_reg   <= cmd.out_last;
            out_handle_reg <= (cmd.out_kind == KIND_SCHEDULED || cmd.out_kind == KIND_FIRED)
                              ? 4'(best_idx_reg) : 4'd0;
            out_queue_reg  <= (cmd.out_kind == KIND_FIRED) ? best_slot_reg.queue : 4'd0;
            out_tag_reg    <= (cmd.out_kind == KIND_FIRED) ? best_slot_reg.tag : 16'd0;
            if (cmd.out_kind == KIND_NEXT)
            begin
                out_delta_reg <= (found_reg && best_val_reg[47:32] == 16'd0)
                                 ? best_val_reg[31:0] : '1;
            end
            else
            begin
                out_delta_reg <= 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            valid_reg     <= '0;
            en_reg        <= '0;
            done_reg      <= '0;
            idx_reg       <= '0;
            issue_reg     <= 1'b0;
            p_vld_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_clr)
            begin
                idx_reg   <= '0;
                issue_reg <= 1'b1;
                p_vld_reg <= 1'b0;
                found_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                p_vld_reg <= issue_reg;
                if (issue_reg)
                begin
                    idx_reg   <= idx_reg + IW'(1);
                    issue_reg <= (idx_reg != LAST_IDX);
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.purge)
            begin
                valid_reg <= valid_reg & en_reg;
                done_reg  <= '0;
                now_reg   <= now_reg + 48'd1;
            end
            if (cmd.cancel && cancel_ok && valid_reg[cancel_idx])
            begin
                en_reg[cancel_idx] <= 1'b0;
            end
            if (cmd.sched)
            begin
                valid_reg[best_idx_reg] <= 1'b1;
                en_reg[best_idx_reg]    <= 1'b1;
            end
            if (cmd.fire)
            begin
                done_reg[best_idx_reg] <= 1'b1;
                if (!best_slot_reg.repeat_flag)
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.found     = found_reg;
    assign stat.scan_done = p_vld_reg && (p_idx_reg == LAST_IDX);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_kind        = out_kind_reg;
    assign out_handle      = out_handle_reg;
    assign out_fired_queue = out_queue_reg;
    assign out_fired_tag   = out_tag_reg;
    assign out_next_delta  = out_delta_reg;
    assign out_last        = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/tds_ctrl.sv =====
// tds_ctrl: command sequencer of the timer deadline scheduler
// depends on tds_pkg; drives tds_dp through dp_cmd_t
`default_nettype none
module tds_ctrl
    import tds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_command,
    output logic            in_ready,
    input  wire dp_stat_t   stat,
    output dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCHED_OUT,
        ST_DUE,
        ST_FIRE,
        ST_DELTA,
        ST_REPORT,
        ST_CANCEL
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.scan_mode = SCAN_FREE;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    unique case (in_command)
                        CMD_SCHEDULE:
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_FREE;
                        end
                        CMD_TICK:
                        begin
                            cmd.purge    = 1'b1;
                            cmd.scan_clr = 1'b1;
                            state_next   = ST_DUE;
                        end
                        CMD_CANCEL:
                        begin
                            state_next = ST_CANCEL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FREE:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_mode = SCAN_FREE;
                if (stat.scan_done)
                begin
                    state_next = ST_SCHED_OUT;
                end
            end
            ST_SCHED_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    cmd.sched    = stat.found;
                    cmd.out_kind = stat.found ? KIND_SCHEDULED : KIND_FULL;
                    state_next   = ST_IDLE;
                end
            end
            ST_DUE:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_mode = SCAN_DUE;
                if (stat.scan_done)
                begin
                    state_next = ST_FIRE;
                end
            end
            ST_FIRE:
            begin
                if (!stat.found)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_DELTA;
                end
                else if (stat.out_free)
                begin
                    cmd.fire     = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_FIRED;
                    cmd.scan_clr = 1'b1;
                    state_next   = ST_DUE;
                end
            end
            ST_DELTA:
            begin
                cmd.scan_run  = 1'b1;
                cmd.scan_mode = SCAN_DELTA;
                if (stat.scan_done)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_NEXT;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CANCEL:
            begin
                cmd.cancel = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/timer_deadline_scheduler_unit.sv =====
// timer_deadline_scheduler_unit: top level of the timer deadline scheduler
// depends on tds_pkg, tds_in_if, tds_out_if, tds_ctrl, tds_dp
//
// channel   dir  carries
// in_ch     in   command, interval, repeat_flag, target_queue, task_tag, cancel_handle
// out_ch    out  kind, handle, fired_queue, fired_tag, next_delta, last
//
// schedule runs a free-slot pass, a tick F+1 due passes and a delta pass for F fired timers:
// each pass is one read a cycle from the slot memory through a registered read port
// one item is in work at a time; the next is taken once the last result is registered
// a stalled result holds the block in its output state until out_ch.ready
// reset clears the time counter and the slot valid and enable bits; no clearing pass
`default_nettype none
module timer_deadline_scheduler_unit
    import tds_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tds_in_if.sink    in_ch,
    tds_out_if.source out_ch
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    tds_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_command (in_ch.command),
        .in_ready   (in_ch.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    tds_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_interval      (in_ch.interval),
        .in_repeat_flag   (in_ch.repeat_flag),
        .in_target_queue  (in_ch.target_queue),
        .in_task_tag      (in_ch.task_tag),
        .in_cancel_handle (in_ch.cancel_handle),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (out_ch.valid),
        .out_ready        (out_ch.ready),
        .out_kind         (out_ch.kind),
        .out_handle       (out_ch.handle),
        .out_fired_queue  (out_ch.fired_queue),
        .out_fired_tag    (out_ch.fired_tag),
        .out_next_delta   (out_ch.next_delta),
        .out_last         (out_ch.last)
    );

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.command == CMD_TICK) |=> !in_ch.ready)
        else $error("tick accepted without entering the scan");

    a_not_last_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last) |-> (out_ch.kind == KIND_FIRED))
        else $error("non-final result is not a fired timer");

    a_fire_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> (stat.found && stat.out_free))
        else $error("fire issued without a due timer or a free output");

endmodule
`default_nettype wire

// ===== test/tb_timer_deadline_scheduler_unit.sv =====
// tb_timer_deadline_scheduler_unit: self-checking bench for the timer deadline scheduler
// depends on tds_pkg, tds_in_if, tds_out_if and timer_deadline_scheduler_unit
// a local timer-table model predicts every result beat, compared in order on out_ch
`default_nettype none
module tb_timer_deadline_scheduler_unit;
    import tds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = SLOTS_DEF;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [47:0] HALF = 48'h8000_0000_0000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  handle;
        logic [3:0]  queue;
        logic [15:0] tag;
        logic [31:0] delta;
        logic        last;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    bit   quiet_send = 1'b0;
    bit   stall_on = 1'b1;
    int   stall_left = 0;
    int   cyc = 0;

    tds_in_if  in_ch ();
    tds_out_if out_ch ();

    timer_deadline_scheduler_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #4 clk = ~clk;

    // timer table model
    logic [47:0] now_ticks;
    bit          t_valid   [NSLOT];
    bit          t_enabled [NSLOT];
    logic [47:0] t_deadline[NSLOT];
    logic [31:0] t_interval[NSLOT];
    bit          t_repeat  [NSLOT];
    logic [3:0]  t_queue   [NSLOT];
    logic [15:0] t_tag     [NSLOT];
    result_t     pending_results[$];

    function automatic result_t mk(logic [1:0] k, logic [3:0] h, logic [3:0] q,
                                   logic [15:0] tg, logic [31:0] d, logic l);
        result_t r;
        r.kind = k; r.handle = h; r.queue = q; r.tag = tg; r.delta = d; r.last = l;
        return r;
    endfunction

    function automatic void predict_timers(logic [1:0] cmd, logic [31:0] iv, logic rep,
                                           logic [3:0] q, logic [15:0] tg, logic [3:0] ch);
        int          s;
        int          pick;
        logic [47:0] lag;
        logic [47:0] pick_lag;
        logic [47:0] d;
        logic [47:0] best;
        bit          any;
        bit          fired[NSLOT];
        s = 0; pick = 0; lag = '0; pick_lag = '0; d = '0; best = '0; any = 0;
        if (cmd == CMD_SCHEDULE) begin
            if (iv == 0) iv = 1;
            s = 0;
            while (s < NSLOT && t_valid[s]) s++;
            if (s >= NSLOT) begin
                pending_results.push_back(mk(KIND_FULL, 0, 0, 0, 0, 1));
            end
            else begin
                t_valid[s] = 1; t_enabled[s] = 1;
                t_deadline[s] = now_ticks + iv;
                t_interval[s] = iv; t_repeat[s] = rep; t_queue[s] = q; t_tag[s] = tg;
                pending_results.push_back(mk(KIND_SCHEDULED, s[3:0], 0, 0, 0, 1));
            end
        end
        else if (cmd == CMD_CANCEL) begin
            if (t_valid[ch]) t_enabled[ch] = 0;
        end
        else if (cmd == CMD_TICK) begin
            for (s = 0; s < NSLOT; s++) begin
                fired[s] = 0;
                if (t_valid[s] && !t_enabled[s]) t_valid[s] = 0;
            end
            now_ticks = now_ticks + 1;
            forever
            begin
                pick = -1;
                for (s = 0; s < NSLOT; s++) begin
                    if (!t_valid[s] || fired[s]) continue;
                    lag = now_ticks - t_deadline[s];
                    if (lag >= HALF) continue;
                    if (pick < 0 || lag > pick_lag) begin
                        pick = s; pick_lag = lag;
                    end
                end
                if (pick < 0) break;
                fired[pick] = 1;
                pending_results.push_back(mk(KIND_FIRED, pick[3:0], t_queue[pick],
                                             t_tag[pick], 0, 0));
                if (t_repeat[pick]) t_deadline[pick] = t_deadline[pick] + t_interval[pick];
                else t_valid[pick] = 0;
            end
            for (s = 0; s < NSLOT; s++) begin
                if (!t_valid[s]) continue;
                d = t_deadline[s] - now_ticks;
                if (d >= HALF) d = 0;
                if (!any || d < best) begin
                    best = d; any = 1;
                end
            end
            if (!any || best > 48'hFFFF_FFFF) best = 48'hFFFF_FFFF;
            pending_results.push_back(mk(KIND_NEXT, 0, 0, 0, best[31:0], 1));
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_send || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(logic [1:0] cmd, logic [31:0] iv, logic rep, logic [3:0] q,
                             logic [15:0] tg, logic [3:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.interval <= iv;
        in_ch.repeat_flag <= rep;
        in_ch.target_queue <= q;
        in_ch.task_tag <= tg;
        in_ch.cancel_handle <= ch;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        predict_timers(cmd, iv, rep, q, tg, ch);
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk) begin
        result_t w;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat kind", out_ch.kind, 0);
            end
            else begin
                w = pending_results.pop_front();
                if (out_ch.kind !== w.kind) report_mismatch("kind", out_ch.kind, w.kind);
                if (out_ch.handle !== w.handle)
                    report_mismatch("handle", out_ch.handle, w.handle);
                if (out_ch.fired_queue !== w.queue)
                    report_mismatch("fired_queue", out_ch.fired_queue, w.queue);
                if (out_ch.fired_tag !== w.tag)
                    report_mismatch("fired_tag", out_ch.fired_tag, w.tag);
                if (out_ch.next_delta !== w.delta)
                    report_mismatch("next_delta", out_ch.next_delta, w.delta);
                if (out_ch.last !== w.last) report_mismatch("last", out_ch.last, w.last);
            end
        end
    end

    // result backpressure, with stall-free stretches
    always @(negedge clk) begin
        int r;
        cyc++;
        if (cyc % 300 == 0) stall_on = ($urandom_range(0, 2) != 0);
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!stall_on || r < 65) begin
            out_ch.ready <= 1'b1;
        end
        else if (r < 95) begin
            out_ch.ready <= 1'b0;
        end
        else begin
            stall_left = $urandom_range(10, 40);
            out_ch.ready <= 1'b0;
        end
    end

    task automatic test_fill_table();
        send_beat(CMD_SCHEDULE, 32'd0, 1'b0, 4'd0, 16'h0000, 4'd0);
        send_beat(CMD_SCHEDULE, 32'd1, 1'b1, 4'd15, 16'hFFFF, 4'd15);
        send_beat(CMD_SCHEDULE, 32'hFFFF_FFFF, 1'b1, 4'd5, 16'hA5A5, 4'd0);
        for (int i = 3; i < NSLOT; i++)
            send_beat(CMD_SCHEDULE, 32'd1000 + i, 1'(i % 2), i[3:0], 16'(16'h5A5A ^ i),
                      4'd0);
        send_beat(CMD_SCHEDULE, 32'd3, 1'b0, 4'd1, 16'h1234, 4'd0);
    endtask

    task automatic test_cancel_and_tick();
        send_beat(CMD_CANCEL, 0, 0, 0, 0, 4'd3);
        send_beat(CMD_SCHEDULE, 32'd2, 1'b0, 4'd2, 16'h0002, 4'd0);
        send_beat(CMD_TICK, 0, 0, 0, 0, 0);
        send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 4'hF, 16'hFFFF, 4'hF);
        send_beat(CMD_CANCEL, 0, 0, 0, 0, 4'd3);
        send_beat(CMD_TICK, 0, 0, 0, 0, 0);
        drain_results();
        for (int h = 0; h < NSLOT; h++) send_beat(CMD_CANCEL, 0, 0, 0, 0, h[3:0]);
        send_beat(CMD_TICK, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        int          r;
        logic [31:0] iv;
        logic        rep;
        logic [3:0]  q;
        logic [15:0] tg;
        logic [3:0]  ch;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 50) drain_results();
            quiet_send = (i % 120) > 90;
            r = $urandom_range(0, 99);
            iv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
            rep = 1'($urandom_range(0, 1));
            q = 4'($urandom_range(0, 15));
            tg = 16'($urandom_range(0, 65535));
            ch = 4'($urandom_range(0, 15));
            if (r < 38)
                send_beat(CMD_SCHEDULE, iv, rep, q, tg, ch);
            else if (r < 85)
                send_beat(CMD_TICK, $urandom, rep, q, tg, ch);
            else if (r < 97)
                send_beat(CMD_CANCEL, $urandom, rep, q, tg, ch);
            else
                send_beat(CMD_UNUSED, $urandom, rep, q, tg, ch);
        end
        quiet_send = 1'b0;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.command = CMD_SCHEDULE;
        in_ch.interval = '0;
        in_ch.repeat_flag = 1'b0;
        in_ch.target_queue = '0;
        in_ch.task_tag = '0;
        in_ch.cancel_handle = '0;
        now_ticks = '0;
        for (int s = 0; s < NSLOT; s++) begin
            t_valid[s] = 0;
            t_enabled[s] = 0;
        end
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_fill_table();
        test_cancel_and_tick();
        test_random(330);
        drain_results();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
